>>> hdl/mps_pkg.sv
// Package for the multilevel process scheduler: payload structs, table entry
// layout, command, status and class codes, and reset values.
// No dependencies; the top level imports it.
`default_nettype none

package mps_pkg;

  localparam int unsigned SLOTS_DEFAULT = 64;

  localparam logic [15:0] STARVE_LIMIT_RST  = 16'd8000;
  localparam logic [3:0]  QUEUE_MODULUS_RST = 4'd3;

  localparam logic [31:0] RAND_ADD    = 32'd238721;
  localparam int unsigned TICKET_MOD  = 100;
  localparam logic [6:0]  TICKET_MAX  = 7'd100;

  // Reciprocal of the ticket modulus, exact for dividends below 2^31.
  localparam logic [31:0] TICKET_RECIP = 32'd2748779070;
  localparam int unsigned TICKET_SHIFT = 38;

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_ADMIT    = 3'd1;
  localparam logic [2:0] CMD_STATUS   = 3'd2;
  localparam logic [2:0] CMD_CLASS    = 3'd3;
  localparam logic [2:0] CMD_TICKET   = 3'd4;
  localparam logic [2:0] CMD_SCHEDULE = 3'd5;

  localparam logic [1:0] ST_EMPTY    = 2'd0;
  localparam logic [1:0] ST_RUNNABLE = 2'd1;
  localparam logic [1:0] ST_RUNNING  = 2'd2;

  localparam logic [1:0] CL_RR   = 2'd0;
  localparam logic [1:0] CL_LOT  = 2'd1;
  localparam logic [1:0] CL_FCFS = 2'd2;

  localparam logic [7:0] REG_STARVE_LIMIT  = 8'd0;
  localparam logic [7:0] REG_QUEUE_MODULUS = 8'd1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [5:0]  slot;
    logic [15:0] task_id;
    logic [1:0]  new_status;
    logic [1:0]  new_class;
    logic [6:0]  new_ticket;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  picked_slot;
    logic [15:0] picked_id;
    logic [1:0]  picked_class;
  } out_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] id;
    logic [1:0]  cls;
    logic [6:0]  ticket;
    logic [31:0] last_run;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

>>> hdl/multilevel_process_scheduler_unit.sv
// Top level of the multilevel process scheduler: control sequencer around
// one slot table RAM. Depends on mps_pkg and mps_ram.
//
// Usage: commands arrive on in_valid_i/in_data_i and a transfer happens when
// in_valid_i is high and in_stall_o is low. Every command yields exactly one
// result on out_valid_o/out_data_o, transferred when out_stall_i is low.
// Registers are written over cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i; the user must write them only while the block is idle, as the
// block itself does not enforce this. cfg_ready_o is always high.
// One command is in work at a time. A tick advances the time counter; a set
// status, class or ticket command rewrites the slot entry (a ticket only for
// a lottery entry); admit derives a ticket and, unless the modulus is zero, a
// class by remainder; schedule walks the table, and walks it a second time
// when the lottery class supplies the pick. The table walk takes one entry
// per cycle and the remainder unit yields one bit per cycle.
// After reset a clearing pass over every entry empties the table; in_stall_o
// stays high during it. A waiting result is held in the output register
// while the receiver stalls, and the next command can be taken meanwhile.
`default_nettype none

module multilevel_process_scheduler_unit
  import mps_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_t             out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned SUM_W = $clog2(SLOTS * TICKET_MOD + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_MUL, S_RND, S_RCP, S_TKT, S_DIV, S_ADMIT_WR, S_RMW_RD,
    S_RMW_WR, S_SCAN, S_SCAN_END, S_DECIDE, S_LOT_END, S_PICK_RD, S_PICK_WR,
    S_RESULT
  } state_e;

  typedef enum logic [1:0] {
    DV_TICKET, DV_CLASS, DV_TARGET
  } div_e;

  state_e state_q;
  div_e   dsel_q;
  in_t    in_q;
  out_t   res_q, out_q;
  logic   out_valid_q;

  logic [15:0] starve_q;
  logic [3:0]  mod_q;
  logic [31:0] now_q;
  logic [IDX_W-1:0] rr_last_q;
  logic        rr_valid_q;

  logic [IDX_W-1:0] slot_addr_q, scan_q, p_idx_q, pick_q;
  logic        p_valid_q, pass_b_q;
  logic [1:0]  pcls_q;

  logic        have_rr_q, have_sec_q, have_aft_q, have_lot_q, have_fc_q, lot_got_q;
  logic [IDX_W-1:0] first_rr_q, sec_q, aft_q, fc_idx_q;
  logic [15:0] fc_id_q;
  logic [SUM_W-1:0] sum_q, acc_q, target_q;

  logic [31:0] prod_q, div_q;
  logic [63:0] rcp_q;
  logic [SUM_W-1:0] dsr_q, rem_q;
  logic [5:0]  dcnt_q;
  logic [6:0]  ticket_q;
  logic [1:0]  adm_cls_q;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, rdata;

  logic [31:0] mix, rand_v, tk_rem;
  logic [SUM_W:0] trial;
  logic [SUM_W-1:0] rem_step;
  logic        aged, rdy_rr, rdy_lot, rdy_fc;
  logic [1:0]  cls_eff;
  logic [SUM_W-1:0] acc_new;
  entry_t      aged_e, mod_e;
  logic [6:0]  tk_clamp;

  mps_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign mix    = prod_q + {prod_q[29:0], 2'b00} + RAND_ADD;
  assign rand_v = {1'b0, mix[31:1]};
  assign tk_rem = div_q - 32'(rcp_q >> TICKET_SHIFT) * 32'(TICKET_MOD);
  assign trial  = {rem_q, div_q[31]};
  assign rem_step = (trial >= {1'b0, dsr_q}) ? SUM_W'(trial - {1'b0, dsr_q})
                                             : trial[SUM_W-1:0];

  assign aged = (rdata.status == ST_RUNNABLE) && (rdata.cls != CL_RR) &&
                ((now_q - rdata.last_run) > {16'b0, starve_q});
  assign cls_eff = aged ? CL_RR : rdata.cls;
  assign rdy_rr  = (rdata.status == ST_RUNNABLE) && (cls_eff == CL_RR);
  assign rdy_lot = (rdata.status == ST_RUNNABLE) && (cls_eff == CL_LOT);
  assign rdy_fc  = (rdata.status == ST_RUNNABLE) && (cls_eff == CL_FCFS);
  assign acc_new = acc_q + SUM_W'(rdata.ticket);

  assign tk_clamp = (in_q.new_ticket == 7'd0) ? 7'd1 :
                    (in_q.new_ticket > TICKET_MAX) ? TICKET_MAX : in_q.new_ticket;

  always_comb begin
    aged_e     = rdata;
    aged_e.cls = CL_RR;
    mod_e      = rdata;
    unique case (in_q.cmd)
      CMD_STATUS: mod_e.status = in_q.new_status;
      CMD_CLASS:  mod_e.cls = (in_q.new_class > CL_FCFS) ? CL_FCFS : in_q.new_class;
      default:    mod_e.ticket = tk_clamp;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = slot_addr_q;
    wdata = '0;
    raddr = scan_q;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = scan_q;
      end
      S_ADMIT_WR: begin
        we    = 1'b1;
        wdata = '{status: ST_RUNNABLE, id: in_q.task_id, cls: adm_cls_q,
                  ticket: ticket_q, last_run: now_q};
      end
      S_RMW_RD: raddr = slot_addr_q;
      S_RMW_WR: begin
        we    = (in_q.cmd != CMD_TICKET) || (rdata.cls == CL_LOT);
        wdata = mod_e;
      end
      S_PICK_RD: raddr = pick_q;
      S_PICK_WR: begin
        we             = 1'b1;
        waddr          = pick_q;
        wdata          = rdata;
        wdata.status   = ST_RUNNING;
        wdata.last_run = now_q;
      end
      default: begin
        if (p_valid_q && !pass_b_q && aged) begin
          we    = 1'b1;
          waddr = p_idx_q;
          wdata = aged_e;
        end
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      dsel_q      <= DV_TICKET;
      out_valid_q <= 1'b0;
      starve_q    <= STARVE_LIMIT_RST;
      mod_q       <= QUEUE_MODULUS_RST;
      now_q       <= '0;
      rr_last_q   <= '0;
      rr_valid_q  <= 1'b0;
      scan_q      <= '0;
      p_valid_q   <= 1'b0;
      pass_b_q    <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_STARVE_LIMIT) begin
          starve_q <= cfg_data_i;
        end else if (cfg_index_i == REG_QUEUE_MODULUS) begin
          mod_q <= cfg_data_i[3:0];
        end
      end

      if (out_valid_q && !out_stall_i && (state_q != S_RESULT)) begin
        out_valid_q <= 1'b0;
      end

      p_valid_q <= (state_q == S_SCAN);
      p_idx_q   <= scan_q;

      if (p_valid_q && !pass_b_q) begin
        if (rdy_rr) begin
          if (!have_rr_q) begin
            have_rr_q  <= 1'b1;
            first_rr_q <= p_idx_q;
          end else if (!have_sec_q) begin
            have_sec_q <= 1'b1;
            sec_q      <= p_idx_q;
          end
          if (rr_valid_q && (p_idx_q > rr_last_q) && !have_aft_q) begin
            have_aft_q <= 1'b1;
            aft_q      <= p_idx_q;
          end
        end
        if (rdy_lot) begin
          have_lot_q <= 1'b1;
          sum_q      <= sum_q + SUM_W'(rdata.ticket);
        end
        if (rdy_fc && (!have_fc_q || (rdata.id < fc_id_q))) begin
          have_fc_q <= 1'b1;
          fc_id_q   <= rdata.id;
          fc_idx_q  <= p_idx_q;
        end
      end
      if (p_valid_q && pass_b_q && rdy_lot && !lot_got_q) begin
        acc_q <= acc_new;
        if (acc_new > target_q) begin
          lot_got_q <= 1'b1;
          pick_q    <= p_idx_q;
        end
      end

      unique case (state_q)
        S_CLEAR: begin
          if (scan_q == LAST_IDX) begin
            scan_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            in_q        <= in_data_i;
            slot_addr_q <= IDX_W'(in_data_i.slot);
            res_q       <= '0;
            scan_q      <= '0;
            pass_b_q    <= 1'b0;
            have_rr_q   <= 1'b0;
            have_sec_q  <= 1'b0;
            have_aft_q  <= 1'b0;
            have_lot_q  <= 1'b0;
            have_fc_q   <= 1'b0;
            lot_got_q   <= 1'b0;
            sum_q       <= '0;
            acc_q       <= '0;
            dsel_q      <= DV_TICKET;
            if (in_data_i.cmd == CMD_TICK) begin
              now_q   <= now_q + 32'd1;
              state_q <= S_RESULT;
            end else if (in_data_i.cmd == CMD_SCHEDULE) begin
              state_q <= S_SCAN;
            end else if ((in_data_i.cmd == CMD_ADMIT) &&
                         (32'(in_data_i.slot) < 32'(SLOTS))) begin
              state_q <= S_MUL;
            end else if (((in_data_i.cmd == CMD_STATUS) ||
                          (in_data_i.cmd == CMD_CLASS) ||
                          (in_data_i.cmd == CMD_TICKET)) &&
                         (32'(in_data_i.slot) < 32'(SLOTS))) begin
              state_q <= S_RMW_RD;
            end else begin
              state_q <= S_RESULT;
            end
          end
        end
        S_MUL: begin
          prod_q  <= now_q * now_q;
          state_q <= S_RND;
        end
        S_RND: begin
          div_q <= rand_v;
          if (dsel_q == DV_TICKET) begin
            state_q <= S_RCP;
          end else begin
            dsr_q   <= sum_q;
            rem_q   <= '0;
            dcnt_q  <= 6'd32;
            state_q <= S_DIV;
          end
        end
        S_RCP: begin
          rcp_q   <= 64'(div_q) * 64'(TICKET_RECIP);
          state_q <= S_TKT;
        end
        S_TKT: begin
          ticket_q <= 7'(tk_rem) + 7'd1;
          if (mod_q == 4'd0) begin
            adm_cls_q <= (in_q.task_id == 16'd1) ? CL_RR :
                         (in_q.task_id == 16'd2) ? CL_LOT : CL_FCFS;
            state_q   <= S_ADMIT_WR;
          end else begin
            dsel_q  <= DV_CLASS;
            div_q   <= {in_q.task_id, 16'b0};
            dsr_q   <= SUM_W'(mod_q);
            rem_q   <= '0;
            dcnt_q  <= 6'd16;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt_q != 6'd0) begin
            rem_q  <= rem_step;
            div_q  <= {div_q[30:0], 1'b0};
            dcnt_q <= dcnt_q - 6'd1;
          end else begin
            unique case (dsel_q)
              DV_CLASS: begin
                adm_cls_q <= (rem_q == SUM_W'(1)) ? CL_RR :
                             (rem_q == SUM_W'(2)) ? CL_LOT : CL_FCFS;
                state_q   <= S_ADMIT_WR;
              end
              default: begin
                target_q <= rem_q;
                pass_b_q <= 1'b1;
                scan_q   <= '0;
                state_q  <= S_SCAN;
              end
            endcase
          end
        end
        S_ADMIT_WR: state_q <= S_RESULT;
        S_RMW_RD:   state_q <= S_RMW_WR;
        S_RMW_WR:   state_q <= S_RESULT;
        S_SCAN: begin
          if (scan_q == LAST_IDX) begin
            state_q <= S_SCAN_END;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_SCAN_END: state_q <= pass_b_q ? S_LOT_END : S_DECIDE;
        S_DECIDE: begin
          if (have_rr_q) begin
            pcls_q     <= CL_RR;
            rr_valid_q <= 1'b1;
            if (rr_valid_q) begin
              pick_q    <= have_aft_q ? aft_q : first_rr_q;
              rr_last_q <= have_aft_q ? aft_q : first_rr_q;
            end else begin
              pick_q    <= have_sec_q ? sec_q : first_rr_q;
              rr_last_q <= have_sec_q ? sec_q : first_rr_q;
            end
            state_q <= S_PICK_RD;
          end else if (have_lot_q) begin
            pcls_q <= CL_LOT;
            if (sum_q == '0) begin
              state_q <= S_RESULT;
            end else begin
              dsel_q  <= DV_TARGET;
              state_q <= S_MUL;
            end
          end else if (have_fc_q) begin
            pcls_q  <= CL_FCFS;
            pick_q  <= fc_idx_q;
            state_q <= S_PICK_RD;
          end else begin
            state_q <= S_RESULT;
          end
        end
        S_LOT_END:  state_q <= lot_got_q ? S_PICK_RD : S_RESULT;
        S_PICK_RD:  state_q <= S_PICK_WR;
        S_PICK_WR: begin
          res_q   <= '{found: 1'b1, picked_slot: 6'(pick_q), picked_id: rdata.id,
                       picked_class: pcls_q};
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/mps_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module mps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
